>>> design/ihrp_pkg.sv
`timescale 1ns / 1ps

package ihrp_pkg;

    // Result kinds carried on the result channel's tuser.
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_EOF    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes carried in the result data.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_START     = 3'd1;
    localparam logic [2:0] ERR_HEX_DIGIT = 3'd2;
    localparam logic [2:0] ERR_EOF_FIELD = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd4;
    localparam logic [2:0] ERR_LINE_END  = 3'd5;
    localparam logic [2:0] ERR_TYPE      = 3'd6;

    // Characters with a meaning in the record syntax.
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // Record types that the parser knows.
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    // Checksum byte that an end-of-file record must carry.
    localparam logic [7:0] EOF_CHECKSUM = 8'hFF;

    localparam int unsigned TDATA_W = 32;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex_digit;

    // Decodes one upper-case hex digit; anything else comes back not ok.
    function automatic t_hex_digit hex_decode(input logic [7:0] c);
        t_hex_digit h;
        h.ok    = 1'b0;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'h37);
        end
        return h;
    endfunction

endpackage

>>> design/intel_hex_record_parser_core.sv
`timescale 1ns / 1ps

// Channel      | Dir | Beat content
// -------------+-----+----------------------------------------------------------
// s_axis_*     | in  | tdata[7:0] = one ASCII character of the hex file
// m_axis_*     | out | tuser[1:0] = result kind; tdata = byte address [15:0],
//              |     | byte value [23:16], error code [26:24], zeros [31:27]
//
// A character beat is accepted in any cycle in which the result register is
// empty or is being emptied, and its result, if it has one, shows on the
// result channel in the next cycle. The parser state and the result register
// are the only stages, so one beat per cycle is sustained without a stall.
// Reset is synchronous and active low; it returns the parser to waiting for a
// colon and drops any pending result. A stall on the result side holds the
// result register and, through tready, holds the character stream as well.
// After an error or an end-of-file record all characters are taken and dropped.

module intel_hex_record_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [ihrp_pkg::TDATA_W-1:0] m_axis_tdata,
                        // [15:0] byte_address, [23:16] byte_value,
                        // [26:24] error_code, [31:27] zero
    output logic [1:0]  m_axis_tuser    // [1:0] result_kind
);

    // Parser phases, in the order a record is read.
    localparam logic [3:0] PH_START = 4'd0;
    localparam logic [3:0] PH_COUNT = 4'd1;
    localparam logic [3:0] PH_ADDR  = 4'd2;
    localparam logic [3:0] PH_TYPE  = 4'd3;
    localparam logic [3:0] PH_DATA  = 4'd4;
    localparam logic [3:0] PH_CSUM  = 4'd5;
    localparam logic [3:0] PH_EOL1  = 4'd6;
    localparam logic [3:0] PH_EOL2  = 4'd7;
    localparam logic [3:0] PH_HALT  = 4'd8;

    // Parser state.
    logic [3:0]  r_phase,     n_phase;
    logic        r_low_next,  n_low_next;
    logic [3:0]  r_high_nib,  n_high_nib;
    logic [1:0]  r_digits,    n_digits;
    logic [7:0]  r_length,    n_length;
    logic [7:0]  r_remaining, n_remaining;
    logic [15:0] r_base,      n_base;
    logic [15:0] r_next_addr, n_next_addr;
    logic [7:0]  r_rec_type,  n_rec_type;
    logic [7:0]  r_sum,       n_sum;

    // Result register.
    logic        r_out_valid;
    logic [1:0]  r_out_kind,  n_out_kind;
    logic [15:0] r_out_addr,  n_out_addr;
    logic [7:0]  r_out_value, n_out_value;
    logic [2:0]  r_out_err,   n_out_err;
    logic        n_emit;

    logic                 in_accept;
    ihrp_pkg::t_hex_digit hex;
    logic [7:0]           full_byte;
    logic [7:0]           want_sum;

    // A character is taken whenever the result register can take its result.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign hex       = ihrp_pkg::hex_decode(s_axis_tdata);
    assign full_byte = {r_high_nib, hex.value};
    assign want_sum  = (r_rec_type == ihrp_pkg::REC_EOF) ? ihrp_pkg::EOF_CHECKSUM
                                                        : 8'(8'd0 - r_sum);

    always_comb begin
        n_phase     = r_phase;
        n_low_next  = r_low_next;
        n_high_nib  = r_high_nib;
        n_digits    = r_digits;
        n_length    = r_length;
        n_remaining = r_remaining;
        n_base      = r_base;
        n_next_addr = r_next_addr;
        n_rec_type  = r_rec_type;
        n_sum       = r_sum;

        n_emit      = 1'b0;
        n_out_kind  = ihrp_pkg::KIND_ERROR;
        n_out_addr  = 16'd0;
        n_out_value = 8'd0;
        n_out_err   = ihrp_pkg::ERR_NONE;

        unique case (r_phase)
            PH_START: begin
                if (s_axis_tdata != ihrp_pkg::CHAR_COLON) begin
                    n_phase   = PH_HALT;
                    n_emit    = 1'b1;
                    n_out_err = ihrp_pkg::ERR_START;
                end else begin
                    n_low_next = 1'b0;
                    n_phase    = PH_COUNT;
                end
            end
            PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM: begin
                if (!hex.ok) begin
                    n_phase   = PH_HALT;
                    n_emit    = 1'b1;
                    n_out_err = ihrp_pkg::ERR_HEX_DIGIT;
                end else if (!r_low_next) begin
                    n_high_nib = hex.value;
                    n_low_next = 1'b1;
                end else begin
                    // Second digit: a whole byte is ready for the current field.
                    n_low_next = 1'b0;
                    unique case (r_phase)
                        PH_COUNT: begin
                            n_length    = full_byte;
                            n_remaining = full_byte;
                            n_sum       = full_byte;
                            n_base      = 16'd0;
                            n_digits    = 2'd2;
                            n_phase     = PH_ADDR;
                        end
                        PH_ADDR: begin
                            n_base   = {r_base[7:0], full_byte};
                            n_sum    = 8'(r_sum + full_byte);
                            n_digits = 2'(r_digits - 2'd1);
                            if (r_digits == 2'd1) begin
                                n_next_addr = {r_base[7:0], full_byte};
                                n_phase     = PH_TYPE;
                            end
                        end
                        PH_TYPE: begin
                            n_rec_type = full_byte;
                            if (full_byte == ihrp_pkg::REC_EOF
                                && (r_length != 8'd0 || r_base != 16'd0)) begin
                                n_phase   = PH_HALT;
                                n_emit    = 1'b1;
                                n_out_err = ihrp_pkg::ERR_EOF_FIELD;
                            end else begin
                                n_phase = (r_remaining != 8'd0) ? PH_DATA : PH_CSUM;
                            end
                        end
                        PH_DATA: begin
                            n_sum = 8'(r_sum + full_byte);
                            // Data bytes go out at once; the record verdict
                            // later tells whether they stand.
                            if (r_rec_type == ihrp_pkg::REC_DATA) begin
                                n_emit      = 1'b1;
                                n_out_kind  = ihrp_pkg::KIND_DATA;
                                n_out_addr  = r_next_addr;
                                n_out_value = full_byte;
                            end
                            n_next_addr = 16'(r_next_addr + 16'd1);
                            n_remaining = 8'(r_remaining - 8'd1);
                            if (r_remaining == 8'd1) begin
                                n_phase = PH_CSUM;
                            end
                        end
                        default: begin
                            // Checksum byte.
                            if (full_byte != want_sum) begin
                                n_phase   = PH_HALT;
                                n_emit    = 1'b1;
                                n_out_err = ihrp_pkg::ERR_CHECKSUM;
                            end else begin
                                n_phase = PH_EOL1;
                            end
                        end
                    endcase
                end
            end
            PH_EOL1, PH_EOL2: begin
                if (r_phase == PH_EOL1 && s_axis_tdata == ihrp_pkg::CHAR_CR) begin
                    n_phase = PH_EOL2;
                end else if (s_axis_tdata == ihrp_pkg::CHAR_LF) begin
                    // Line end: the record verdict.
                    n_emit = 1'b1;
                    if (r_rec_type == ihrp_pkg::REC_DATA) begin
                        n_phase    = PH_START;
                        n_out_kind = ihrp_pkg::KIND_RECORD;
                        n_out_addr = r_base;
                    end else if (r_rec_type == ihrp_pkg::REC_EOF) begin
                        n_phase    = PH_HALT;
                        n_out_kind = ihrp_pkg::KIND_EOF;
                    end else begin
                        n_phase   = PH_HALT;
                        n_out_err = ihrp_pkg::ERR_TYPE;
                    end
                end else begin
                    n_phase   = PH_HALT;
                    n_emit    = 1'b1;
                    n_out_err = ihrp_pkg::ERR_LINE_END;
                end
            end
            default: begin
                // Halted: characters are taken and dropped.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_low_next  <= 1'b0;
            r_high_nib  <= 4'd0;
            r_digits    <= 2'd0;
            r_length    <= 8'd0;
            r_remaining <= 8'd0;
            r_base      <= 16'd0;
            r_next_addr <= 16'd0;
            r_rec_type  <= 8'd0;
            r_sum       <= 8'd0;
        end else if (in_accept) begin
            r_phase     <= n_phase;
            r_low_next  <= n_low_next;
            r_high_nib  <= n_high_nib;
            r_digits    <= n_digits;
            r_length    <= n_length;
            r_remaining <= n_remaining;
            r_base      <= n_base;
            r_next_addr <= n_next_addr;
            r_rec_type  <= n_rec_type;
            r_sum       <= n_sum;
        end
    end

    // The result register loads whenever it can take a new beat; it goes empty
    // when its beat leaves and no accepted character brings a new result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= in_accept && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && n_emit) begin
            r_out_kind  <= n_out_kind;
            r_out_addr  <= n_out_addr;
            r_out_value <= n_out_value;
            r_out_err   <= n_out_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {5'd0, r_out_err, r_out_value, r_out_addr};

endmodule

>>> design/ihrp_checker.sv
`timescale 1ns / 1ps

module ihrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [ihrp_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic       out_beat;
    logic [2:0] out_err;

    assign out_beat = m_axis_tvalid && m_axis_tready;
    assign out_err  = m_axis_tdata[26:24];

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // With the result register empty the parser must take characters.
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("character stream stalled with no pending result");

    // Error beats and only error beats carry an error code.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == ihrp_pkg::KIND_ERROR)
            == (out_err != ihrp_pkg::ERR_NONE)))
        else $error("error code does not match result kind");

    // After an error or end-of-file beat the parser is halted and emits nothing.
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && (m_axis_tuser == ihrp_pkg::KIND_ERROR
            || m_axis_tuser == ihrp_pkg::KIND_EOF) |=> !m_axis_tvalid)
        else $error("result after error or end of file");

    // Padding bits stay zero, and the byte value is zero outside data beats.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:27] == 5'd0
            && (m_axis_tuser == ihrp_pkg::KIND_DATA || m_axis_tdata[23:16] == 8'd0))
        else $error("nonzero unused result bits");

endmodule

bind intel_hex_record_parser_core ihrp_checker u_ihrp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
